// File: hw/rtl/rspe_pkg.sv
// Shared types and constants for the relative sinusoidal position embedding unit.
// Holds request/result payload structs, pipeline control and lane structs, Q32, Q29 and Q15 constants.
// No dependencies.
package rspe_pkg;

	localparam int ROW_BITS    = 11;
	localparam int PAIR_BITS   = 8;
	localparam int LEN_BITS    = 11;
	localparam int POS_BITS    = 12;
	localparam int SAMPLE_BITS = 16;
	localparam int PAIRS       = 1 << PAIR_BITS;

	// fixed-point constants, Q32 unless the name says Q29 or Q15
	localparam logic [63:0] LOG2_10000_Q32 = 64'd57070290109;
	localparam logic [63:0] LN2_Q32        = 64'hB17217F8;
	localparam logic [63:0] INV2PI_Q32     = 64'h28BE60DC;
	localparam logic [63:0] MASK32         = 64'hFFFF_FFFF;
	localparam logic [31:0] TWO_PI_Q29     = 32'hC90FDAA2;
	localparam logic [32:0] Q32_ONE        = 33'h1_0000_0000;
	localparam logic [16:0] Q15_MAX        = 17'd32767;

	// quadrant of the phase, in quarter turns
	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_1,
		QUAD_2,
		QUAD_3
	} quad_t;

	typedef struct packed {
		logic [ROW_BITS-1:0]  table_row;
		logic [PAIR_BITS-1:0] pair_index;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sine_value;
		logic signed [SAMPLE_BITS-1:0] cosine_value;
		logic                          cosine_present;
		logic                          row_in_range;
	} out_item_t;

	// control that travels with each pipeline slot
	typedef struct packed {
		logic  valid;
		logic  active;
		logic  row_in_range;
		logic  cos_present;
		logic  swap;
		quad_t quadrant;
	} ctrl_t;

	// series data: angle, running sums and the current term of each lane
	typedef struct packed {
		logic [31:0] x;
		logic [32:0] s_sum;
		logic [32:0] c_sum;
		logic [32:0] s_term;
		logic [32:0] c_term;
	} lanes_t;

endpackage

// File: hw/rtl/rspe_term.sv
// One Taylor term step for the sine and cosine lanes, four pipeline stages.
// Adds or subtracts the previous term into the sums, then forms ((t*x)>>32)*x>>32 / divisor.
// Depends on rspe_pkg.
module rspe_term #(
	parameter int TERM = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rspe_pkg::ctrl_t  up_ctrl,
	input  rspe_pkg::lanes_t up_data,
	output logic             up_stall,
	output rspe_pkg::ctrl_t  dn_ctrl,
	output rspe_pkg::lanes_t dn_data,
	input  logic             dn_stall
);
	import rspe_pkg::*;

	// series divisors (2i)(2i+1) for sine, (2i-1)(2i) for cosine
	localparam int          S_DIV_I   = (2 * TERM) * (2 * TERM + 1);
	localparam int          C_DIV_I   = (2 * TERM - 1) * (2 * TERM);
	localparam logic [31:0] S_DIV     = 32'(S_DIV_I);
	localparam logic [31:0] C_DIV     = 32'(C_DIV_I);
	localparam logic [31:0] S_RECIP   = 32'((64'd1 << 32) / S_DIV_I);
	localparam logic [31:0] C_RECIP   = 32'((64'd1 << 32) / C_DIV_I);
	// previous term enters with a minus sign when its index is odd
	localparam bit          SUBTRACT  = ((TERM - 1) % 2) == 1;

	ctrl_t       ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4;
	lanes_t      data_s1, data_s2, data_s3, data_s4;
	logic [31:0] m2_s_s3, m2_c_s3;
	logic        stall_s1, stall_s2, stall_s3, stall_s4;

	logic [64:0] prod_a_s, prod_a_c;
	logic [63:0] prod_b_s, prod_b_c;
	logic [63:0] prod_c_s, prod_c_c;
	logic [32:0] sum_s_nxt, sum_c_nxt;
	logic [31:0] rem_s, rem_c, q_s, q_c;

	// hold a stage only when it is full and the next one holds
	assign stall_s4 = ctrl_s4.valid && dn_stall;
	assign stall_s3 = ctrl_s3.valid && stall_s4;
	assign stall_s2 = ctrl_s2.valid && stall_s3;
	assign stall_s1 = ctrl_s1.valid && stall_s2;
	assign up_stall = stall_s1;

	// stage 1: accumulate previous term, first product
	assign sum_s_nxt = SUBTRACT ? (up_data.s_sum - up_data.s_term)
	                            : (up_data.s_sum + up_data.s_term);
	assign sum_c_nxt = SUBTRACT ? (up_data.c_sum - up_data.c_term)
	                            : (up_data.c_sum + up_data.c_term);
	assign prod_a_s  = up_data.s_term * up_data.x;
	assign prod_a_c  = up_data.c_term * up_data.x;

	// stage 2: second product
	assign prod_b_s = data_s1.s_term[31:0] * data_s1.x;
	assign prod_b_c = data_s1.c_term[31:0] * data_s1.x;

	// stage 3: reciprocal estimate of the quotient
	assign prod_c_s = data_s2.s_term[31:0] * S_RECIP;
	assign prod_c_c = data_s2.c_term[31:0] * C_RECIP;

	// stage 4: estimate is low by at most one, fix with one compare
	assign rem_s = m2_s_s3 - 32'(data_s3.s_term[31:0] * S_DIV);
	assign rem_c = m2_c_s3 - 32'(data_s3.c_term[31:0] * C_DIV);
	assign q_s   = (rem_s >= S_DIV) ? (data_s3.s_term[31:0] + 32'd1) : data_s3.s_term[31:0];
	assign q_c   = (rem_c >= C_DIV) ? (data_s3.c_term[31:0] + 32'd1) : data_s3.c_term[31:0];

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			if (!stall_s1) ctrl_s1 <= up_ctrl;
			if (!stall_s2) ctrl_s2 <= ctrl_s1;
			if (!stall_s3) ctrl_s3 <= ctrl_s2;
			if (!stall_s4) ctrl_s4 <= ctrl_s3;
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (!stall_s1) begin
			data_s1.x      <= up_data.x;
			data_s1.s_sum  <= sum_s_nxt;
			data_s1.c_sum  <= sum_c_nxt;
			data_s1.s_term <= {1'b0, prod_a_s[63:32]};
			data_s1.c_term <= {1'b0, prod_a_c[63:32]};
		end
		if (!stall_s2) begin
			data_s2.x      <= data_s1.x;
			data_s2.s_sum  <= data_s1.s_sum;
			data_s2.c_sum  <= data_s1.c_sum;
			data_s2.s_term <= {1'b0, prod_b_s[63:32]};
			data_s2.c_term <= {1'b0, prod_b_c[63:32]};
		end
		if (!stall_s3) begin
			data_s3.x      <= data_s2.x;
			data_s3.s_sum  <= data_s2.s_sum;
			data_s3.c_sum  <= data_s2.c_sum;
			data_s3.s_term <= {1'b0, prod_c_s[63:32]};
			data_s3.c_term <= {1'b0, prod_c_c[63:32]};
			m2_s_s3        <= data_s2.s_term[31:0];
			m2_c_s3        <= data_s2.c_term[31:0];
		end
		if (!stall_s4) begin
			data_s4.x      <= data_s3.x;
			data_s4.s_sum  <= data_s3.s_sum;
			data_s4.c_sum  <= data_s3.c_sum;
			data_s4.s_term <= {1'b0, q_s};
			data_s4.c_term <= {1'b0, q_c};
		end
	end

	assign dn_ctrl = ctrl_s4;
	assign dn_data = data_s4;

endmodule

// File: hw/rtl/relative_sinusoidal_position_embedding_unit.sv
// Throughput: one request per cycle while the output is not stalled; each of the eight
// Taylor terms takes four stages (two products, a reciprocal multiply, a one-step quotient
// fix), which sets the depth. A stage holds only while full and blocked downstream, so
// empty slots fill up under stall. Reset clears all valid bits and sets the sequence
// length to 1. Depends on rspe_pkg, rspe_term.
module relative_sinusoidal_position_embedding_unit #(
	parameter int MODEL_WIDTH = 512,
	parameter int MAX_FRAMES  = 1024,
	parameter int ANGLE_BITS  = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rspe_pkg::LEN_BITS-1:0]  cfg_data,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  rspe_pkg::in_item_t             item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output rspe_pkg::out_item_t            result
);
	import rspe_pkg::*;

	localparam int LEN_LIMIT = (1 << LEN_BITS) - 1;
	localparam int LEN_CAP   = (MAX_FRAMES < LEN_LIMIT) ? MAX_FRAMES : LEN_LIMIT;

	// frequency of pair k in turns per position, evaluated at elaboration
	function automatic logic [ANGLE_BITS-1:0] rom_word(input logic [PAIR_BITS-1:0] k);
		logic [63:0] e;
		logic [63:0] n;
		logic [63:0] y;
		logic [63:0] sum;
		logic [63:0] term;
		logic [63:0] v;
		e    = ((64'(k) << 1) * LOG2_10000_Q32) / 64'(MODEL_WIDTH);
		n    = e >> 32;
		y    = ((e & MASK32) * LN2_Q32) >> 32;
		sum  = 64'd1 << 32;
		term = 64'd1 << 32;
		for (int i = 1; i <= 14; i++) begin
			term = ((term * y) >> 32) / 64'(i);
			if ((i & 1) != 0) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		v = (n < 64'd64) ? (sum >> n) : 64'd0;
		v = (v * INV2PI_Q32) >> 32;
		if (ANGLE_BITS >= 32) begin
			v = v << (ANGLE_BITS - 32);
		end else begin
			v = v >> (32 - ANGLE_BITS);
		end
		return ANGLE_BITS'(v);
	endfunction

	// Q32 magnitude to rounded, saturated Q1.15 with optional negation
	function automatic logic signed [SAMPLE_BITS-1:0] to_q15(input logic [32:0] v,
			input logic neg);
		logic [33:0]            rnd;
		logic [SAMPLE_BITS-1:0] mag;
		rnd = {1'b0, v} + 34'd65536;
		mag = (rnd[33:17] > Q15_MAX) ? Q15_MAX[15:0] : rnd[32:17];
		return neg ? -$signed(mag) : $signed(mag);
	endfunction

	logic [LEN_BITS-1:0]   seq_len_q;
	logic [ANGLE_BITS-1:0] freq_rom [PAIRS];

	ctrl_t                    ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s36;
	logic signed [POS_BITS-1:0] pos_s1;
	logic [ANGLE_BITS-1:0]    freq_s1;
	logic [ANGLE_BITS-1:0]    phase_s2;
	lanes_t                   data_s3;
	logic [32:0]              s_sum_s36, c_sum_s36;
	logic                     valid_s37;
	out_item_t                result_s37;

	logic stall_s1, stall_s2, stall_s3, stall_s36, stall_s37;

	ctrl_t  chain_ctrl  [9];
	lanes_t chain_data  [9];
	logic   chain_stall [9];

	logic [LEN_BITS-1:0]          len_eff;
	logic                         in_range_c, pair_ok_c, cos_ok_c;
	logic signed [POS_BITS-1:0]   pos_c;
	logic signed [ANGLE_BITS+POS_BITS:0] phase_prod;
	logic [31:0]                  turn;
	logic [29:0]                  rem_turn, angle_c;
	logic                         swap_c;
	logic [61:0]                  x_prod;
	logic [32:0]                  s0, c0;
	logic signed [SAMPLE_BITS-1:0] sv_c, cv_c;

	// pair frequency table
	for (genvar g = 0; g < PAIRS; g++) begin : g_rom
		assign freq_rom[g] = rom_word(PAIR_BITS'(g));
	end

	// sequence length register, always writable
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_len_q <= LEN_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			seq_len_q <= cfg_data;
		end
	end

	// stall chain: a stage holds only when full and blocked downstream
	assign stall_s37      = valid_s37 && !result_ready;
	assign stall_s36      = ctrl_s36.valid && stall_s37;
	assign chain_stall[8] = stall_s36;
	assign stall_s3       = ctrl_s3.valid && chain_stall[0];
	assign stall_s2       = ctrl_s2.valid && stall_s3;
	assign stall_s1       = ctrl_s1.valid && stall_s2;
	assign item_ready     = !stall_s1;

	// stage 1: row checks, relative position, table lookup
	assign len_eff    = (seq_len_q > LEN_BITS'(LEN_CAP)) ? LEN_BITS'(LEN_CAP) : seq_len_q;
	assign in_range_c = (len_eff != '0) &&
		({1'b0, item.table_row} <= ({len_eff, 1'b0} - 12'd2));
	assign pair_ok_c  = 32'({item.pair_index, 1'b0}) < 32'(MODEL_WIDTH);
	assign cos_ok_c   = 32'({item.pair_index, 1'b1}) < 32'(MODEL_WIDTH);
	assign pos_c      = $signed({1'b0, len_eff} - 12'd1 - {1'b0, item.table_row});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (!stall_s1) begin
			ctrl_s1.valid        <= item_valid;
			ctrl_s1.active       <= in_range_c && pair_ok_c;
			ctrl_s1.row_in_range <= in_range_c;
			ctrl_s1.cos_present  <= cos_ok_c;
			ctrl_s1.swap         <= 1'b0;
			ctrl_s1.quadrant     <= QUAD_0;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s1) begin
			pos_s1  <= pos_c;
			freq_s1 <= freq_rom[item.pair_index];
		end
	end

	// stage 2: phase in turns, modulo one turn
	assign phase_prod = pos_s1 * $signed({1'b0, freq_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (!stall_s2) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2) phase_s2 <= phase_prod[ANGLE_BITS-1:0];
	end

	// stage 3: octant folding and angle in radians
	if (ANGLE_BITS >= 32) begin : g_turn_top
		assign turn = phase_s2[ANGLE_BITS-1 -: 32];
	end else begin : g_turn_pad
		assign turn = {phase_s2, {(32 - ANGLE_BITS){1'b0}}};
	end

	assign rem_turn = turn[29:0];
	assign swap_c   = rem_turn[29];
	assign angle_c  = swap_c ? 30'(31'h4000_0000 - {1'b0, rem_turn}) : rem_turn;
	assign x_prod   = angle_c * TWO_PI_Q29;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (!stall_s3) begin
			ctrl_s3.valid        <= ctrl_s2.valid;
			ctrl_s3.active       <= ctrl_s2.active;
			ctrl_s3.row_in_range <= ctrl_s2.row_in_range;
			ctrl_s3.cos_present  <= ctrl_s2.cos_present;
			ctrl_s3.swap         <= swap_c;
			ctrl_s3.quadrant     <= quad_t'(turn[31:30]);
		end
	end

	// series start: sums empty, first terms x and one
	always_ff @(posedge clk) begin
		if (!stall_s3) begin
			data_s3.x      <= x_prod[60:29];
			data_s3.s_sum  <= '0;
			data_s3.c_sum  <= '0;
			data_s3.s_term <= {1'b0, x_prod[60:29]};
			data_s3.c_term <= Q32_ONE;
		end
	end

	// eight Taylor term steps
	assign chain_ctrl[0] = ctrl_s3;
	assign chain_data[0] = data_s3;

	for (genvar g = 0; g < 8; g++) begin : g_term
		rspe_term #(
			.TERM(g + 1)
		) u_term (
			.clk     (clk),
			.arst_n  (arst_n),
			.up_ctrl (chain_ctrl[g]),
			.up_data (chain_data[g]),
			.up_stall(chain_stall[g]),
			.dn_ctrl (chain_ctrl[g+1]),
			.dn_data (chain_data[g+1]),
			.dn_stall(chain_stall[g+1])
		);
	end

	// stage 36: add the last term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s36 <= '0;
		end else if (!stall_s36) begin
			ctrl_s36 <= chain_ctrl[8];
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s36) begin
			s_sum_s36 <= chain_data[8].s_sum + chain_data[8].s_term;
			c_sum_s36 <= chain_data[8].c_sum + chain_data[8].c_term;
		end
	end

	// stage 37: unfold octant and quadrant, convert to Q1.15
	assign s0 = ctrl_s36.swap ? c_sum_s36 : s_sum_s36;
	assign c0 = ctrl_s36.swap ? s_sum_s36 : c_sum_s36;

	always_comb begin
		case (ctrl_s36.quadrant)
			QUAD_0: begin
				sv_c = to_q15(s0, 1'b0);
				cv_c = to_q15(c0, 1'b0);
			end
			QUAD_1: begin
				sv_c = to_q15(c0, 1'b0);
				cv_c = to_q15(s0, 1'b1);
			end
			QUAD_2: begin
				sv_c = to_q15(s0, 1'b1);
				cv_c = to_q15(c0, 1'b1);
			end
			QUAD_3: begin
				sv_c = to_q15(c0, 1'b1);
				cv_c = to_q15(s0, 1'b0);
			end
			default: begin
				sv_c = '0;
				cv_c = '0;
			end
		endcase
		if (!ctrl_s36.active) begin
			sv_c = '0;
			cv_c = '0;
		end
		if (!ctrl_s36.cos_present) cv_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s37 <= 1'b0;
		end else if (!stall_s37) begin
			valid_s37 <= ctrl_s36.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s37) begin
			result_s37.sine_value     <= sv_c;
			result_s37.cosine_value   <= cv_c;
			result_s37.cosine_present <= ctrl_s36.cos_present;
			result_s37.row_in_range   <= ctrl_s36.row_in_range;
		end
	end

	assign result_valid = valid_s37;
	assign result       = result_s37;

	// an accepted request always lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> ctrl_s1.valid)
		else $error("accepted request missing from first stage");

	// no stage holds unless the output is blocked
	a_no_spurious_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!(result_valid && !result_ready) |-> item_ready)
		else $error("input stalled while output is free");

	// rows outside the table give zero values
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.row_in_range |->
			(result.sine_value == 16'sd0 && result.cosine_value == 16'sd0))
		else $error("nonzero value for a row outside the table");

endmodule

// File: tb/sv/rspe_entry_checker.sv
// Scoreboard for the relative sinusoidal position embedding unit: watches all three channels,
// predicts each table entry from its request and compares it with the result stream.
// Depends on rspe_pkg for the payload structs and the quadrant enum.
module rspe_entry_checker #(
	parameter int MODEL_WIDTH = 512,
	parameter int MAX_FRAMES  = 1024,
	parameter int ANGLE_BITS  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rspe_pkg::LEN_BITS-1:0] cfg_data,
	input  logic                          item_valid,
	input  logic                          item_ready,
	input  rspe_pkg::in_item_t            item,
	input  logic                          result_valid,
	input  logic                          result_ready,
	input  rspe_pkg::out_item_t           result,
	output int                            mismatches,
	output int                            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import rspe_pkg::*;

	// fixed-point constants of the table math, Q32 unless noted
	localparam longint unsigned LOG2_1E4  = 64'd57070290109;
	localparam longint unsigned LN2       = 64'hB172_17F8;
	localparam longint unsigned INV_2PI   = 64'h28BE_60DC;
	localparam longint unsigned TWO_PI_29 = 64'hC90F_DAA2;	// Q29
	localparam longint unsigned LOW32     = 64'hFFFF_FFFF;
	localparam longint unsigned ONE_Q32   = 64'd1 << 32;
	localparam int              SHOWN     = 30;

	typedef struct packed {
		in_item_t  request;
		out_item_t entry;
	} due_entry_t;

	logic [LEN_BITS-1:0] seq_len;
	due_entry_t          entries_due[$];

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= SHOWN)
			$display("%0t ns  mismatch: %s", $time, msg);
	endtask

	// Q32 magnitude to Q1.15, rounded and saturated, then signed by quadrant
	function automatic logic signed [15:0] to_q15(input longint unsigned v, input bit neg);
		longint unsigned   m;
		logic signed [15:0] q;
		m = (v + 64'd65536) >> 17;
		if (m > 64'd32767)
			m = 64'd32767;
		q = m[15:0];
		return neg ? -q : q;
	endfunction

	// expected table entry for one request under the current sequence length
	function automatic out_item_t predict_entry(input in_item_t req);
		longint unsigned len, row, k, e, n, y, freq, term, word, phase, t, r, a, x;
		longint unsigned ssum, csum, sterm, cterm, s0, c0;
		bit              in_range, pair_ok, cos_ok, swap;
		quad_t           quad;
		logic signed [15:0] sv, cv;
		out_item_t       want;
		sv = '0;
		cv = '0;
		len = seq_len;
		if (len > MAX_FRAMES)
			len = MAX_FRAMES;
		row = req.table_row;
		k = req.pair_index;
		in_range = (len >= 1) && (row <= 2 * len - 2);
		pair_ok = (2 * k) < MODEL_WIDTH;
		cos_ok = (2 * k + 1) < MODEL_WIDTH;

		if (in_range && pair_ok) begin
			// pair frequency 10000^(-2k/D): split the exponent into 2^-n * e^-y
			e = (2 * k * LOG2_1E4) / MODEL_WIDTH;
			n = e >> 32;
			y = ((e & LOW32) * LN2) >> 32;
			freq = ONE_Q32;
			term = ONE_Q32;
			for (int i = 1; i <= 14; i++) begin
				term = ((term * y) >> 32) / i;
				if (i % 2)
					freq -= term;
				else
					freq += term;
			end
			freq = (n < 64) ? (freq >> n) : 64'd0;
			word = (freq * INV_2PI) >> 32;
			if (ANGLE_BITS >= 32)
				word = word << (ANGLE_BITS - 32);
			else
				word = word >> (32 - ANGLE_BITS);

			// phase in turns; the position wraps as two's complement
			phase = ((len - 1 - row) * word) & ((64'd1 << ANGLE_BITS) - 1);
			if (ANGLE_BITS >= 32)
				t = phase >> (ANGLE_BITS - 32);
			else
				t = phase << (32 - ANGLE_BITS);
			t &= LOW32;
			quad = quad_t'(t[31:30]);
			r = t & 64'h3FFF_FFFF;
			swap = r >= (64'd1 << 29);
			a = swap ? ((64'd1 << 30) - r) : r;
			x = (a * TWO_PI_29) >> 29;

			// sine and cosine on the first octant
			ssum = x;
			sterm = x;
			csum = ONE_Q32;
			cterm = ONE_Q32;
			for (int i = 1; i <= 8; i++) begin
				sterm = ((((sterm * x) >> 32) * x) >> 32) / ((2 * i) * (2 * i + 1));
				cterm = ((((cterm * x) >> 32) * x) >> 32) / ((2 * i - 1) * (2 * i));
				if (i % 2) begin
					ssum -= sterm;
					csum -= cterm;
				end else begin
					ssum += sterm;
					csum += cterm;
				end
			end
			s0 = swap ? csum : ssum;
			c0 = swap ? ssum : csum;

			case (quad)
				QUAD_0: begin
					sv = to_q15(s0, 1'b0);
					cv = to_q15(c0, 1'b0);
				end
				QUAD_1: begin
					sv = to_q15(c0, 1'b0);
					cv = to_q15(s0, 1'b1);
				end
				QUAD_2: begin
					sv = to_q15(s0, 1'b1);
					cv = to_q15(c0, 1'b1);
				end
				default: begin
					sv = to_q15(c0, 1'b1);
					cv = to_q15(s0, 1'b0);
				end
			endcase
			if (!cos_ok)
				cv = '0;
		end

		want.sine_value = sv;
		want.cosine_value = cv;
		want.cosine_present = cos_ok;
		want.row_in_range = in_range;
		return want;
	endfunction

	task automatic check_field(input string name, input logic signed [16:0] got,
			input logic signed [16:0] want, input in_item_t req);
		if (got !== want)
			report($sformatf("%s got %0d expected %0d (row %0d pair %0d len %0d)",
				name, got, want, req.table_row, req.pair_index, seq_len));
	endtask

	// track the register, queue predictions, compare results in order
	always @(posedge clk or negedge arst_n) begin
		due_entry_t head;
		if (!arst_n) begin
			seq_len = 1;
			entries_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				seq_len = cfg_data;
			if (item_valid && item_ready)
				entries_due.push_back('{request: item, entry: predict_entry(item)});
			if (result_valid && result_ready) begin
				if (entries_due.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					head = entries_due.pop_front();
					check_field("sine_value", result.sine_value, head.entry.sine_value,
						head.request);
					check_field("cosine_value", result.cosine_value, head.entry.cosine_value,
						head.request);
					check_field("cosine_present", result.cosine_present,
						head.entry.cosine_present, head.request);
					check_field("row_in_range", result.row_in_range,
						head.entry.row_in_range, head.request);
				end
			end
		end
		outstanding = entries_due.size();
	end

endmodule

// File: tb/sv/tb_relative_sinusoidal_position_embedding_unit.sv
// Top of the position embedding testbench: clock, reset, request and register stimulus,
// result back-pressure, idle watchdog and verdict. Depends on rspe_pkg, the unit and
// rspe_entry_checker.
module tb_relative_sinusoidal_position_embedding_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import rspe_pkg::*;

	localparam int MODEL_WIDTH = 512;
	localparam int MAX_FRAMES  = 1024;
	localparam int ANGLE_BITS  = 32;
	localparam int PERIOD      = 8;
	localparam int LATENCY     = 37;
	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 156;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [LEN_BITS-1:0] cfg_data = '0;
	logic                item_valid = 1'b0;
	logic                item_ready;
	in_item_t            item = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	out_item_t           result;
	int                  mismatches;
	int                  outstanding;
	int                  idle_cycles = 0;
	int                  burst_left = 0;
	int                  ready_run = 0;
	bit                  rx_on = 1'b0;
	int                  cur_len = 1;
	logic                handshake;

	always #(PERIOD / 2) clk = ~clk;

	relative_sinusoidal_position_embedding_unit #(
		.MODEL_WIDTH(MODEL_WIDTH),
		.MAX_FRAMES (MAX_FRAMES),
		.ANGLE_BITS (ANGLE_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	rspe_entry_checker #(
		.MODEL_WIDTH(MODEL_WIDTH),
		.MAX_FRAMES (MAX_FRAMES),
		.ANGLE_BITS (ANGLE_BITS)
	) scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	assign handshake = (item_valid && item_ready) || (cfg_valid && cfg_ready)
		|| (result_valid && result_ready);

	// end the run when no channel moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if (handshake)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// result back-pressure: runs of ready and stall of random length
	always @(negedge clk) begin
		if (ready_run == 0) begin
			rx_on = $urandom_range(0, 3) != 0;
			ready_run = rx_on ? $urandom_range(1, 40) : $urandom_range(1, 12);
		end
		ready_run--;
		result_ready <= rx_on;
	end

	// one register write, issued from a falling edge with the block idle
	task automatic write_len(input logic [LEN_BITS-1:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_len = value;
	endtask

	// one request; bursts of random length separated by random gaps
	task automatic issue(input logic [ROW_BITS-1:0] row, input logic [PAIR_BITS-1:0] k);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				item_valid <= 1'b0;
				item <= in_item_t'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item <= '{table_row: row, pair_index: k};
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// rows mostly inside the table, some on its edge and some anywhere
	function automatic logic [ROW_BITS-1:0] pick_row(input int len_setting);
		int len, sel;
		len = (len_setting > MAX_FRAMES) ? MAX_FRAMES : len_setting;
		sel = $urandom_range(0, 9);
		if (len >= 1 && sel == 0)
			return ROW_BITS'(2 * len - 2);
		if (sel == 1)
			return ROW_BITS'(2 * len - 1);
		if (len >= 1 && sel < 8)
			return ROW_BITS'($urandom_range(0, 2 * len - 2));
		return ROW_BITS'($urandom_range(0, 2047));
	endfunction

	initial begin
		int len_setting;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// length after reset: one row only
		issue(0, 0);
		issue(0, 255);
		issue(1, 0);
		issue(2046, 255);
		issue(2047, 128);
		drain();

		// full table: zero, extreme and unit positions, alternating bit patterns
		write_len(1024);
		issue(1023, 0);
		issue(0, 0);
		issue(2046, 0);
		issue(2046, 255);
		issue(0, 255);
		issue(1022, 1);
		issue(1024, 1);
		issue(2047, 0);
		issue(11'h555, 8'hAA);
		issue(11'h2AA, 8'h55);
		issue(1000, 3);
		drain();

		// zero length: nothing in range
		write_len(0);
		issue(0, 0);
		issue(0, 255);
		drain();

		// length beyond the frame limit saturates
		write_len(2047);
		issue(2046, 7);
		issue(2047, 7);
		issue(0, 100);
		drain();

		// random phases over several lengths, extremes included
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: len_setting = 1024;
				1: len_setting = 1;
				2: len_setting = $urandom_range(2, 64);
				3: len_setting = 2047;
				4: len_setting = $urandom_range(2, 1023);
				5: len_setting = 0;
				6: len_setting = $urandom_range(1025, 2046);
				default: len_setting = 1024;
			endcase
			write_len(LEN_BITS'(len_setting));
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue(pick_row(cur_len), PAIR_BITS'($urandom_range(0, 255)));
			drain();
		end

		repeat (2 * LATENCY) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
